>>> design/stal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stal_pkg
// Shared constants, types and state codes for the stereo level meter.
// ----------------------------------------------------------------------------
package stal_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;

    localparam logic [1:0] CFG_SLEW_SCALE = 2'd0;
    localparam logic [1:0] CFG_ZERO_STEP  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd2;

    localparam logic [15:0] SLEW_SCALE_RST = 16'd403;
    localparam logic [15:0] ZERO_STEP_RST  = 16'd256;
    localparam logic [15:0] WINDOW_LEN_RST = 16'd1881;

    // Window statistics frozen at report time.
    typedef struct packed {
        logic [CHANNELS-1:0][SAMPLE_BITS:0]     max_slew;
        logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   peak_mag;
        logic [CHANNELS-1:0][63:0]              sum_squares;
        logic [CHANNELS-1:0][23:0]              longest_run;
        logic [16:0]                            sample_count;
    } report_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SLEW,
        B_DIV,
        B_CHECK,
        B_RMS1,
        B_RMS2,
        B_PEAK,
        B_DONE
    } back_state_t;

endpackage

>>> design/stal_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stal_isqrt
// Iterative floor square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module stal_isqrt import stal_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rad_reg,  rad_next;
    logic [34:0] rem_reg,  rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] rem_try;
    logic [34:0] trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_try   = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start && !busy_reg) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_try >= trial) begin
                rem_next  = rem_try - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_try;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> design/stal_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stal_fifo
// Two-entry queue of window reports between the front and the back.
// ----------------------------------------------------------------------------
module stal_fifo import stal_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  report_t      push_data,
    output logic         full,
    input  wire logic    pop,
    output report_t      pop_data,
    output logic         empty,
    output logic [1:0]   level
);

    report_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg,    cnt_next;
    logic        do_push, do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign level    = cnt_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/stal_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stal_front
// Per-sample statistics update; closes a window into a report when it ends.
// ----------------------------------------------------------------------------
module stal_front import stal_pkg::*; (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  samples,
    input  wire logic [15:0]                           zero_step,
    input  wire logic [15:0]                           window_len,
    input  wire logic                                  queue_full,
    output logic                                       push,
    output report_t                                    push_data
);

    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] prev_reg,    prev_next;
    logic [CHANNELS-1:0][SAMPLE_BITS:0]   slew_reg,    slew_next;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] peak_reg,    peak_next;
    logic [CHANNELS-1:0][63:0]            sum_reg,     sum_next;
    logic [CHANNELS-1:0][23:0]            run_reg,     run_next;
    logic [CHANNELS-1:0][23:0]            longest_reg, longest_next;
    logic [CHANNELS-1:0]                  pos_reg,     pos_next;
    logic [16:0]                          count_reg,   count_next;

    logic [CHANNELS-1:0][SAMPLE_BITS:0]   slew_upd;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] peak_upd;
    logic [CHANNELS-1:0][63:0]            sum_upd;
    logic [CHANNELS-1:0][23:0]            run_upd;
    logic [CHANNELS-1:0][23:0]            longest_upd;
    logic [CHANNELS-1:0][SAMPLE_BITS:0]   diff;
    logic [CHANNELS-1:0][SAMPLE_BITS:0]   slew_abs;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] mag;
    logic [CHANNELS-1:0][2*SAMPLE_BITS-1:0] sq;
    logic [CHANNELS-1:0][64:0]            sum_wide;
    logic [CHANNELS-1:0][24:0]            run_wide;
    logic [CHANNELS-1:0][23:0]            run_sat;
    logic [16:0]                          count_upd;
    logic                                 accept;
    logic                                 report;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        prev_next    = prev_reg;
        slew_next    = slew_reg;
        peak_next    = peak_reg;
        sum_next     = sum_reg;
        run_next     = run_reg;
        longest_next = longest_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;

        for (int c = 0; c < CHANNELS; c++) begin
            diff[c]     = {samples[c][SAMPLE_BITS-1], samples[c]}
                        - {prev_reg[c][SAMPLE_BITS-1], prev_reg[c]};
            slew_abs[c] = diff[c][SAMPLE_BITS] ? (~diff[c] + 1'b1) : diff[c];
            mag[c]      = samples[c][SAMPLE_BITS-1] ? (~samples[c] + 1'b1) : samples[c];
            sq[c]       = {{SAMPLE_BITS{1'b0}}, mag[c]} * {{SAMPLE_BITS{1'b0}}, mag[c]};
            sum_wide[c] = {1'b0, sum_reg[c]} + {17'd0, sq[c]};
            run_wide[c] = {1'b0, run_reg[c]} + {9'd0, zero_step};
            run_sat[c]  = run_wide[c][24] ? 24'hFF_FFFF : run_wide[c][23:0];

            slew_upd[c]    = (slew_abs[c] > slew_reg[c]) ? slew_abs[c] : slew_reg[c];
            peak_upd[c]    = (mag[c] > peak_reg[c]) ? mag[c] : peak_reg[c];
            sum_upd[c]     = sum_wide[c][64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[c][63:0];
            longest_upd[c] = (run_sat[c] > longest_reg[c]) ? run_sat[c] : longest_reg[c];
            run_upd[c]     = run_sat[c];
            pos_next[c]    = pos_reg[c];
            // A zero sample keeps the polarity; only a strict sign flips it.
            if (pos_reg[c] && samples[c][SAMPLE_BITS-1]) begin
                pos_next[c] = 1'b0;
                run_upd[c]  = '0;
            end else if (!pos_reg[c] && !samples[c][SAMPLE_BITS-1]
                         && (samples[c] != '0)) begin
                pos_next[c] = 1'b1;
                run_upd[c]  = '0;
            end
        end

        count_upd = (count_reg == 17'h1_FFFF) ? count_reg : count_reg + 17'd1;
        report    = count_upd > {1'b0, window_len};

        push_data.max_slew     = slew_upd;
        push_data.peak_mag     = peak_upd;
        push_data.sum_squares  = sum_upd;
        push_data.longest_run  = longest_upd;
        push_data.sample_count = count_upd;
        push                   = accept && report;

        if (!accept) begin
            pos_next = pos_reg;
        end else begin
            prev_next = samples;
            if (report) begin
                slew_next    = '0;
                peak_next    = '0;
                sum_next     = '0;
                run_next     = '0;
                longest_next = '0;
                count_next   = '0;
            end else begin
                slew_next    = slew_upd;
                peak_next    = peak_upd;
                sum_next     = sum_upd;
                run_next     = run_upd;
                longest_next = longest_upd;
                count_next   = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            slew_reg    <= '0;
            peak_reg    <= '0;
            sum_reg     <= '0;
            run_reg     <= '0;
            longest_reg <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
        end else begin
            prev_reg    <= prev_next;
            slew_reg    <= slew_next;
            peak_reg    <= peak_next;
            sum_reg     <= sum_next;
            run_reg     <= run_next;
            longest_reg <= longest_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/stal_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stal_back
// Turns one queued report into output values: scaled slew, a restoring
// divide for the mean square, and square roots on a shared root unit.
// ----------------------------------------------------------------------------
module stal_back import stal_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          queue_empty,
    input  report_t            queue_data,
    output logic               pop,
    input  wire logic [15:0]   slew_scale,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [175:0]       out_data
);

    back_state_t            state_reg,  state_next;
    report_t                rep_reg,    rep_next;
    logic                   ch_reg,     ch_next;
    logic [5:0]             dcnt_reg,   dcnt_next;
    logic [16:0]            drem_reg,   drem_next;
    logic [63:0]            quo_reg,    quo_next;
    logic [1:0][27:0]       slew_res_reg, slew_res_next;
    logic [1:0][16:0]       peak_res_reg, peak_res_next;
    logic [1:0][16:0]       rms_res_reg,  rms_res_next;
    logic                   oval_reg,   oval_next;
    logic [175:0]           odata_reg,  odata_next;

    logic                   sq_start;
    logic [63:0]            sq_operand;
    logic                   sq_done;
    logic [31:0]            sq_root;
    logic [40:0]            slew_prod;
    logic [17:0]            dtry;
    logic                   dge;

    stal_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_operand),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb begin
        state_next    = state_reg;
        rep_next      = rep_reg;
        ch_next       = ch_reg;
        dcnt_next     = dcnt_reg;
        drem_next     = drem_reg;
        quo_next      = quo_reg;
        slew_res_next = slew_res_reg;
        peak_res_next = peak_res_reg;
        rms_res_next  = rms_res_reg;
        oval_next     = oval_reg;
        odata_next    = odata_reg;
        pop           = 1'b0;
        sq_start      = 1'b0;
        sq_operand    = {31'd0, rep_reg.peak_mag[ch_reg], 9'd0};
        slew_prod     = {16'd0, rep_reg.max_slew[ch_reg]} * {25'd0, slew_scale};
        dtry          = {drem_reg, quo_reg[63]};
        dge           = dtry >= {1'b0, rep_reg.sample_count};

        if (oval_reg && out_ready) begin
            oval_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE: begin
                if (!queue_empty) begin
                    pop        = 1'b1;
                    rep_next   = queue_data;
                    ch_next    = 1'b0;
                    state_next = B_SLEW;
                end
            end
            B_SLEW: begin
                slew_res_next[ch_reg] = (slew_prod[40:36] != 5'd0) ? 28'hFFF_FFFF
                                                                   : slew_prod[35:8];
                drem_next  = '0;
                quo_next   = rep_reg.sum_squares[ch_reg];
                dcnt_next  = 6'd63;
                state_next = B_DIV;
            end
            B_DIV: begin
                drem_next = dge ? 17'(dtry - {1'b0, rep_reg.sample_count}) : dtry[16:0];
                quo_next  = {quo_reg[62:0], dge};
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd0) begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK: begin
                // A mean square at or above full scale reads as exactly one.
                if (quo_reg[63:46] != '0) begin
                    rms_res_next[ch_reg] = 17'h1_0000;
                    sq_start             = 1'b1;
                    state_next           = B_PEAK;
                end else begin
                    sq_operand = {quo_reg[45:0], 18'd0};
                    sq_start   = 1'b1;
                    state_next = B_RMS1;
                end
            end
            B_RMS1: begin
                sq_operand = {32'd0, sq_root};
                if (sq_done) begin
                    sq_start   = 1'b1;
                    state_next = B_RMS2;
                end
            end
            B_RMS2: begin
                if (sq_done) begin
                    rms_res_next[ch_reg] = sq_root[16:0];
                    sq_start             = 1'b1;
                    state_next           = B_PEAK;
                end
            end
            B_PEAK: begin
                if (sq_done) begin
                    peak_res_next[ch_reg] = sq_root[16:0];
                    if (ch_reg) begin
                        state_next = B_DONE;
                    end else begin
                        ch_next    = 1'b1;
                        state_next = B_SLEW;
                    end
                end
            end
            B_DONE: begin
                if (!oval_reg || out_ready) begin
                    oval_next  = 1'b1;
                    odata_next = {4'd0,
                                  rep_reg.longest_run[1], rep_reg.longest_run[0],
                                  rms_res_reg[1], rms_res_reg[0],
                                  peak_res_reg[1], peak_res_reg[0],
                                  slew_res_reg[1], slew_res_reg[0]};
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rep_reg      <= rep_next;
        ch_reg       <= ch_next;
        dcnt_reg     <= dcnt_next;
        drem_reg     <= drem_next;
        quo_reg      <= quo_next;
        slew_res_reg <= slew_res_next;
        peak_res_reg <= peak_res_next;
        rms_res_reg  <= rms_res_next;
        odata_reg    <= odata_next;
        if (!aresetn) begin
            state_reg <= B_IDLE;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

endmodule
`default_nettype wire

>>> design/stereo_audio_level_meter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_audio_level_meter_unit
// Stereo peak, slew, RMS and zero-crossing meter with windowed reports.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  s_        in         s_tvalid/s_tready  one stereo sample pair
//  m_        out        m_tvalid/m_tready  one window report
//  cfg_      in         cfg_valid/ready    register index and 16-bit value
//
// The front takes each sample pair and updates the running statistics.
// When a window closes, its statistics go into a two-entry report queue.
// The back works through one report at a time, with the 64-step restoring
// divider and up to three 32-step root passes per channel.
// s_tready drops only while the report queue is full. Reset is synchronous
// and clears all statistics, the polarity and the registers to defaults.
// ----------------------------------------------------------------------------
module stereo_audio_level_meter_unit import stal_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [23:0] left_sample, [47:24] right_sample
    input  wire logic [47:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [27:0] left_scaled_slew, [55:28] right_scaled_slew, [72:56] peak_root_left,
    // [89:73] peak_root_right, [106:90] rms_root_left,
    // [123:107] rms_root_right, [147:124] zero_run_left,
    // [171:148] zero_run_right, [175:172] zero
    output logic [175:0]       m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    logic [15:0] slew_scale_reg, slew_scale_next;
    logic [15:0] zero_step_reg,  zero_step_next;
    logic [15:0] window_len_reg, window_len_next;

    logic        q_push, q_pop, q_full, q_empty;
    logic [1:0]  q_level;
    report_t     q_in, q_out;

    // Configuration is always accepted; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        slew_scale_next = slew_scale_reg;
        zero_step_next  = zero_step_reg;
        window_len_next = window_len_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLEW_SCALE: slew_scale_next = cfg_data;
                CFG_ZERO_STEP:  zero_step_next  = cfg_data;
                CFG_WINDOW_LEN: window_len_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slew_scale_reg <= SLEW_SCALE_RST;
            zero_step_reg  <= ZERO_STEP_RST;
            window_len_reg <= WINDOW_LEN_RST;
        end else begin
            slew_scale_reg <= slew_scale_next;
            zero_step_reg  <= zero_step_next;
            window_len_reg <= window_len_next;
        end
    end

    stal_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .samples    (s_tdata),
        .zero_step  (zero_step_reg),
        .window_len (window_len_reg),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    stal_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .level     (q_level)
    );

    stal_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .queue_data  (q_out),
        .pop         (q_pop),
        .slew_scale  (slew_scale_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // The queue never holds more than its two entries.
    assert property (@(posedge aclk) disable iff (!aresetn) q_level != 2'd3)
        else $error("report queue level out of range");

    // A report is only pushed while the queue has room.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("report pushed into a full queue");

    // Nothing is popped from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("report popped from an empty queue");

endmodule
`default_nettype wire

>>> test/stereo_audio_level_meter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_audio_level_meter_unit_tb
// Self-checking bench for the stereo level meter. A predictor tracks the
// per-channel window statistics and computes each expected report, which is
// compared field by field with the reports leaving the master port.
// ----------------------------------------------------------------------------
module stereo_audio_level_meter_unit_tb;
    import stal_pkg::*;

    // One expected window report, fields in port order.
    typedef struct {
        logic [27:0] slew [2];
        logic [16:0] peak_root [2];
        logic [16:0] rms_root [2];
        logic [23:0] zero_run [2];
    } meter_report_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [47:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [175:0]  m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = CFG_SLEW_SCALE;
    logic [15:0]   cfg_data = '0;

    stereo_audio_level_meter_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: a mirror of the registers and the window statistics.
    logic [15:0]  reg_slew_scale, reg_zero_step, reg_window_len;
    logic signed [23:0] last_sample [2];
    logic [24:0]  top_slew [2];
    logic [23:0]  top_mag [2];
    logic [63:0]  energy [2];
    logic [16:0]  window_count;
    logic [23:0]  cur_run [2];
    logic [23:0]  best_run [2];
    logic         positive [2];

    logic [47:0]      pair_queue [$];
    meter_report_t    report_queue [$];
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               send_hold = 1'b0;
    int               errors = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic meter_reset_state();
        reg_slew_scale = SLEW_SCALE_RST;
        reg_zero_step  = ZERO_STEP_RST;
        reg_window_len = WINDOW_LEN_RST;
        for (int c = 0; c < 2; c++) begin
            last_sample[c] = 0; top_slew[c] = 0; top_mag[c] = 0; energy[c] = 0;
            cur_run[c] = 0; best_run[c] = 0; positive[c] = 1'b0;
        end
        window_count = 0;
    endtask

    // Updates the statistics with one sample pair and queues a report when
    // the window closes.
    task automatic meter_predict(input logic [47:0] pair);
        logic signed [24:0] x, d;
        logic [24:0]  slew;
        logic [23:0]  mag;
        logic [63:0]  sq, s, m;
        logic [24:0]  run;
        meter_report_t rep;
        for (int c = 0; c < 2; c++) begin
            x = $signed(pair[c*24 +: 24]);
            d = x - last_sample[c];
            slew = d < 0 ? -d : d;
            mag = x < 0 ? 24'(-x) : 24'(x);
            sq = 64'(mag) * 64'(mag);
            if (slew > top_slew[c]) top_slew[c] = slew;
            last_sample[c] = x[23:0];
            if (mag > top_mag[c]) top_mag[c] = mag;
            if (energy[c] > ~64'd0 - sq) energy[c] = ~64'd0;
            else energy[c] = energy[c] + sq;
            run = 25'(cur_run[c]) + 25'(reg_zero_step);
            cur_run[c] = run > 25'hFFFFFF ? 24'hFFFFFF : run[23:0];
            if (best_run[c] < cur_run[c]) best_run[c] = cur_run[c];
            if (positive[c] && x < 0) begin
                positive[c] = 1'b0; cur_run[c] = 0;
            end else if (!positive[c] && x > 0) begin
                positive[c] = 1'b1; cur_run[c] = 0;
            end
        end
        if (window_count < 17'h1FFFF) window_count++;
        if (window_count <= reg_window_len) return;
        for (int c = 0; c < 2; c++) begin
            s = (64'(top_slew[c]) * 64'(reg_slew_scale)) >> 8;
            rep.slew[c] = s > 64'hFFFFFFF ? 28'hFFFFFFF : s[27:0];
            rep.peak_root[c] = 17'(int_sqrt(64'(top_mag[c]) << 9));
            m = energy[c] / 64'(window_count);
            if (m >= (64'd1 << 46)) rep.rms_root[c] = 17'd65536;
            else rep.rms_root[c] = 17'(int_sqrt(int_sqrt(m << 18)));
            rep.zero_run[c] = best_run[c];
            top_slew[c] = 0; top_mag[c] = 0; energy[c] = 0;
            cur_run[c] = 0; best_run[c] = 0;
        end
        window_count = 0;
        report_queue.push_back(rep);
    endtask

    // Driver: presents queued sample pairs and keeps valid steady while held.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                meter_predict(s_tdata);
                void'(pair_queue.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // Hold the current item.
            end else if (pair_queue.size() > (s_tvalid && s_tready ? 0 : 0) && !send_hold
                         && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pair_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each report with the oldest expectation.
    always @(posedge aclk) begin
        meter_report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_queue.size() == 0) begin
                $error("report with no expectation");
                errors++;
            end else begin
                e = report_queue.pop_front();
                for (int c = 0; c < 2; c++) begin
                    if (m_tdata[c*28 +: 28] !== e.slew[c]) begin
                        $error("slew[%0d] exp %0d got %0d", c, e.slew[c], m_tdata[c*28 +: 28]);
                        errors++;
                    end
                    if (m_tdata[56 + c*17 +: 17] !== e.peak_root[c]) begin
                        $error("peak_root[%0d] exp %0d got %0d", c, e.peak_root[c],
                               m_tdata[56 + c*17 +: 17]);
                        errors++;
                    end
                    if (m_tdata[90 + c*17 +: 17] !== e.rms_root[c]) begin
                        $error("rms_root[%0d] exp %0d got %0d", c, e.rms_root[c],
                               m_tdata[90 + c*17 +: 17]);
                        errors++;
                    end
                    if (m_tdata[124 + c*24 +: 24] !== e.zero_run[c]) begin
                        $error("zero_run[%0d] exp %0d got %0d", c, e.zero_run[c],
                               m_tdata[124 + c*24 +: 24]);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'($signed($urandom_range(64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // Waits until the driver has nothing left and no report is outstanding,
    // then lets the back end drain before touching a register.
    task automatic wait_idle();
        while (pair_queue.size() != 0 || s_tvalid || report_queue.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLEW_SCALE: reg_slew_scale = val;
            CFG_ZERO_STEP:  reg_zero_step = val;
            default:        reg_window_len = val;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] ss, input logic [15:0] zs,
                            input logic [15:0] wl);
        wait_idle();
        write_reg(CFG_SLEW_SCALE, ss);
        write_reg(CFG_ZERO_STEP, zs);
        write_reg(CFG_WINDOW_LEN, wl);
    endtask

    task automatic add_random(input int n);
        repeat (n) pair_queue.push_back({rand_sample(), rand_sample()});
    endtask

    initial begin
        meter_reset_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, zero samples, sign flips, report per sample.
        set_regs(16'hFFFF, 16'hFFFF, 16'd0);
        pair_queue.push_back({24'h7FFFFF, 24'h800000});
        pair_queue.push_back({24'h800000, 24'h7FFFFF});
        pair_queue.push_back({24'h000000, 24'h000000});
        pair_queue.push_back({24'h000001, 24'hFFFFFF});
        set_regs(16'd0, 16'hFFFF, 16'd6);
        repeat (4) pair_queue.push_back({24'h800000, 24'h800000});
        repeat (6) pair_queue.push_back({24'h000000, 24'h000000});
        set_regs(16'd403, 16'd256, 16'd8);
        repeat (5) pair_queue.push_back({rand_sample(), rand_sample()});
        // Lowering the window mid-window closes it on the next sample.
        wait_idle();
        write_reg(CFG_WINDOW_LEN, 16'd1);
        pair_queue.push_back({24'h123456, 24'hEDCBA9});

        // Random part in three idling phases, registers varied between them.
        set_regs(16'($urandom), 16'($urandom), 16'd9);
        send_idle_pct = 23; recv_idle_pct = 47;
        add_random(250);
        wait_idle();
        // The sender pauses until every expected report is back.
        send_hold = 1'b1;
        add_random(10);
        while (report_queue.size() != 0) @(posedge aclk);
        send_hold = 1'b0;
        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(3)));
        send_idle_pct = 47; recv_idle_pct = 23;
        add_random(240);
        set_regs(16'hFFFF, 16'd1, 16'd20);
        send_idle_pct = 0; recv_idle_pct = 0;
        add_random(250);
        while (pair_queue.size() != 0 || s_tvalid || report_queue.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("stereo_audio_level_meter_unit_tb OK");
        end else begin
            $display("stereo_audio_level_meter_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("stereo_audio_level_meter_unit_tb NOT OK");
        $finish;
    end

endmodule
